[sv/arm_operand2_barrel_shifter_unit_assert.svh]
// assertion macros shared by the operand shifter rtl
`ifndef ARM_OPERAND2_BARREL_SHIFTER_UNIT_ASSERT_SVH
`define ARM_OPERAND2_BARREL_SHIFTER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define AOBS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define AOBS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define AOBS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define AOBS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[sv/aobs_pkg.sv]
// shared types, constants and helpers for the operand shifter
`default_nettype none
package aobs_pkg;
	localparam int WORD_W  = 32;
	localparam int ROT_W   = 5;
	localparam int AMT_W   = 8;
	localparam int FIELD_W = 12;

	typedef enum logic [1:0] {
		SH_LSL = 2'd0,
		SH_LSR = 2'd1,
		SH_ASR = 2'd2,
		SH_ROR = 2'd3
	} shift_t;

	// which bit of the rotated word is the shifter carry
	typedef enum logic [1:0] {
		CSEL_NONE  = 2'd0,
		CSEL_BIT0  = 2'd1,
		CSEL_BIT31 = 2'd2
	} csel_t;

	typedef struct packed {
		logic [WORD_W-1:0] data;
		logic [ROT_W-1:0]  rot;
		logic [WORD_W-1:0] mask;
		logic              fill;
		csel_t             csel;
		logic              cw;
	} ctrl_t;

	function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] d,
			input logic [ROT_W-1:0] k);
		logic [2*WORD_W-1:0] w;
		w = {d, d} >> k;
		return w[WORD_W-1:0];
	endfunction
endpackage
`default_nettype wire

[sv/aobs_decode.sv]
// operand field decode: every form becomes a right rotation, a keep mask and a fill bit
`default_nettype none
module aobs_decode import aobs_pkg::*; (
	input  wire logic               func,
	input  wire logic [FIELD_W-1:0] operand_field,
	input  wire logic               set_flags,
	input  wire logic [WORD_W-1:0]  rm_value,
	input  wire logic [WORD_W-1:0]  rs_value,
	output ctrl_t                   ctrl
);
	logic [AMT_W-1:0] amt;
	logic             big;
	logic             over;
	shift_t           sh;

	always_comb begin
		amt  = operand_field[4] ? rs_value[AMT_W-1:0] : {3'b000, operand_field[11:7]};
		sh   = shift_t'(operand_field[6:5]);
		big  = amt >= AMT_W'(WORD_W);
		over = amt > AMT_W'(WORD_W);

		ctrl.data = rm_value;
		ctrl.rot  = '0;
		ctrl.mask = '1;
		ctrl.fill = 1'b0;
		ctrl.csel = CSEL_NONE;
		ctrl.cw   = 1'b0;

		if (func) begin
			ctrl.data = {{(WORD_W-8){1'b0}}, operand_field[7:0]};
			ctrl.rot  = {operand_field[11:8], 1'b0};
		end else begin
			ctrl.cw = set_flags && (sh != SH_ROR);
			unique case (sh)
				SH_ROR: begin
					ctrl.rot = amt[ROT_W-1:0];
				end
				SH_LSL: begin
					// left shift is a rotation right by the complement, low bits cleared
					if (amt != '0) begin
						ctrl.rot  = ROT_W'(0) - amt[ROT_W-1:0];
						ctrl.mask = big ? '0 : ({WORD_W{1'b1}} << amt[ROT_W-1:0]);
						ctrl.csel = over ? CSEL_NONE : CSEL_BIT0;
					end
				end
				SH_LSR, SH_ASR: begin
					if (amt != '0) begin
						ctrl.rot  = amt[ROT_W-1:0];
						ctrl.mask = big ? '0 : ({WORD_W{1'b1}} >> amt[ROT_W-1:0]);
						ctrl.fill = (sh == SH_ASR) && rm_value[WORD_W-1];
						ctrl.csel = over ? CSEL_NONE : CSEL_BIT31;
					end
				end
			endcase
		end
	end
endmodule
`default_nettype wire

[sv/arm_operand2_barrel_shifter_unit.sv]
// Second-operand shifter for data-processing instructions. Takes one request every cycle
// while the output is not stalled: stage one decodes the operand field into a
// right rotation, a keep mask and a fill bit, stage two rotates by the coarse part of the
// amount (multiples of four), stage three rotates by the rest, picks the carry and
// applies mask and fill into the output register. Each stage moves on when the stage
// after it is empty or moving, so a stalled output holds only the stages behind it.
`default_nettype none
`include "arm_operand2_barrel_shifter_unit_assert.svh"
module arm_operand2_barrel_shifter_unit import aobs_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               func,
	input  wire logic [FIELD_W-1:0] operand_field,
	input  wire logic               set_flags,
	input  wire logic [WORD_W-1:0]  rm_value,
	input  wire logic [WORD_W-1:0]  rs_value,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [WORD_W-1:0]       operand_value,
	output logic                    carry_out,
	output logic                    carry_write
);
	ctrl_t ctrl;

	logic              valid_s1, valid_s2, valid_s3;
	logic              adv_s1, adv_s2, adv_s3;
	ctrl_t             ctrl_s1;
	logic [WORD_W-1:0] data_s2;
	logic [1:0]        rot_s2;
	logic [WORD_W-1:0] mask_s2;
	logic              fill_s2;
	csel_t             csel_s2;
	logic              cw_s2;
	logic [WORD_W-1:0] value_s3;
	logic              carry_s3;
	logic              cw_s3;
	logic [WORD_W-1:0] rot_full;
	logic [WORD_W-1:0] value_next;
	logic              carry_next;

	aobs_decode u_decode (
		.func          (func),
		.operand_field (operand_field),
		.set_flags     (set_flags),
		.rm_value      (rm_value),
		.rs_value      (rs_value),
		.ctrl          (ctrl)
	);

	assign adv_s3   = !valid_s3 || out_ready;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) ctrl_s1 <= ctrl;
		if (adv_s2 && valid_s1) begin
			data_s2 <= rotr(ctrl_s1.data, {ctrl_s1.rot[ROT_W-1:2], 2'b00});
			rot_s2  <= ctrl_s1.rot[1:0];
			mask_s2 <= ctrl_s1.mask;
			fill_s2 <= ctrl_s1.fill;
			csel_s2 <= ctrl_s1.csel;
			cw_s2   <= ctrl_s1.cw;
		end
		if (adv_s3 && valid_s2) begin
			value_s3 <= value_next;
			carry_s3 <= carry_next;
			cw_s3    <= cw_s2;
		end
	end

	always_comb begin
		rot_full   = rotr(data_s2, {3'b000, rot_s2});
		value_next = (rot_full & mask_s2) | (~mask_s2 & {WORD_W{fill_s2}});
		// carry is the last bit out, taken before the mask clears it
		case (csel_s2)
			CSEL_BIT0:  carry_next = rot_full[0];
			CSEL_BIT31: carry_next = rot_full[WORD_W-1];
			default:    carry_next = 1'b0;
		endcase
	end

	assign out_valid     = valid_s3;
	assign operand_value = value_s3;
	assign carry_out     = carry_s3;
	assign carry_write   = cw_s3;

	// back-pressure reaches the input only when every stage is full
	`AOBS_ASSERT_IMP(a_ready_full, clk, arst_n, !in_ready,
		valid_s1 && valid_s2 && valid_s3 && !out_ready)
	// immediate requests never keep bits back and never write carry
	`AOBS_ASSERT_NXT(a_imm_decode, clk, arst_n, in_valid && in_ready && func,
		valid_s1 && (ctrl_s1.mask == {WORD_W{1'b1}}) && !ctrl_s1.cw &&
		(ctrl_s1.csel == CSEL_NONE))
	// a bubble in stage two shows up at the output after a delivered result
	`AOBS_ASSERT_NXT(a_bubble, clk, arst_n, out_valid && out_ready && !valid_s2,
		!out_valid)
endmodule
`default_nettype wire

[dv/tb.sv]
// self-checking testbench for the second-operand barrel shifter
`timescale 1ns / 1ps
module tb;
	import aobs_pkg::*;

	typedef struct {
		logic               func;
		logic [FIELD_W-1:0] field;
		logic               sf;
		logic [WORD_W-1:0]  rm;
		logic [WORD_W-1:0]  rs;
		bit                 drain;
	} op_req_t;

	typedef struct {
		logic [WORD_W-1:0] value;
		logic              cy;
		logic              cw;
	} op_res_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               func = 1'b0;
	logic [FIELD_W-1:0] operand_field = '0;
	logic               set_flags = 1'b0;
	logic [WORD_W-1:0]  rm_value = '0;
	logic [WORD_W-1:0]  rs_value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [WORD_W-1:0]  operand_value;
	logic               carry_out;
	logic               carry_write;

	op_req_t     req_q[$];
	op_res_t     operand_due[$];
	int unsigned n_bad = 0;
	int unsigned tx_gap = 0;
	int unsigned tx_calm = 0;
	int unsigned rx_wait = 0;
	int unsigned rx_calm = 0;

	arm_operand2_barrel_shifter_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.operand_field(operand_field),
		.set_flags(set_flags),
		.rm_value(rm_value),
		.rs_value(rs_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.operand_value(operand_value),
		.carry_out(carry_out),
		.carry_write(carry_write)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [WORD_W-1:0] ror32(logic [WORD_W-1:0] v, int unsigned n);
		int unsigned k;
		k = n % 32;
		if (k == 0)
			return v;
		return (v >> k) | (v << (32 - k));
	endfunction

	function automatic op_res_t shift_operand(op_req_t r);
		op_res_t                  o;
		shift_t                   kind;
		int unsigned              amt;
		logic                     sign;
		logic signed [WORD_W-1:0] srm;
		o.value = '0;
		o.cy = 1'b0;
		o.cw = 1'b0;
		if (r.func) begin
			o.value = ror32({24'd0, r.field[7:0]}, 2 * r.field[11:8]);
			return o;
		end
		kind = shift_t'(r.field[6:5]);
		amt = r.field[4] ? 32'(r.rs[7:0]) : 32'(r.field[11:7]);
		sign = r.rm[31];
		srm = r.rm;
		if (kind == SH_ROR) begin
			o.value = ror32(r.rm, amt);
		end else if (amt == 0) begin
			o.value = r.rm;
		end else begin
			case (kind)
				SH_LSL: begin
					if (amt < 32) begin
						o.value = r.rm << amt;
						o.cy = r.rm[32 - amt];
					end else if (amt == 32) begin
						o.cy = r.rm[0];
					end
				end
				SH_LSR: begin
					if (amt < 32) begin
						o.value = r.rm >> amt;
						o.cy = r.rm[amt - 1];
					end else if (amt == 32) begin
						o.cy = sign;
					end
				end
				default: begin
					if (amt < 32) begin
						o.value = srm >>> amt;
						o.cy = r.rm[amt - 1];
					end else begin
						o.value = {WORD_W{sign}};
						o.cy = (amt == 32) ? sign : 1'b0;
					end
				end
			endcase
		end
		o.cw = r.sf && (kind != SH_ROR);
		return o;
	endfunction

	// wait before the next request, with runs of back-to-back traffic
	function automatic int unsigned draw_wait(inout int unsigned calm);
		if (calm > 0) begin
			calm = calm - 1;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			calm = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 11);
	endfunction

	task automatic add_imm(logic [FIELD_W-1:0] fld, logic sf);
		op_req_t r;
		r.func = 1'b1;
		r.field = fld;
		r.sf = sf;
		r.rm = $urandom;
		r.rs = $urandom;
		r.drain = 1'b0;
		req_q.push_back(r);
	endtask

	// register-mode request; the amount goes into the field or the low byte of rs
	task automatic add_shift(shift_t kind, bit by_rs, int unsigned amt, logic sf,
			logic [WORD_W-1:0] rm);
		op_req_t r;
		r.func = 1'b0;
		r.sf = sf;
		r.rm = rm;
		r.drain = 1'b0;
		r.rs = $urandom;
		r.field = FIELD_W'($urandom);
		r.field[6:4] = {kind, by_rs};
		if (by_rs)
			r.rs[7:0] = 8'(amt);
		else
			r.field[11:7] = 5'(amt);
		req_q.push_back(r);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		logic    held;
		op_req_t nx;
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_gap <= 0;
		end else begin
			held = in_valid && !in_ready;
			if (in_valid && in_ready) begin
				nx.func = func;
				nx.field = operand_field;
				nx.sf = set_flags;
				nx.rm = rm_value;
				nx.rs = rs_value;
				nx.drain = 1'b0;
				operand_due.push_back(shift_operand(nx));
			end
			if (!held) begin
				if (tx_gap != 0) begin
					in_valid <= 1'b0;
					tx_gap <= tx_gap - 1;
				end else if (req_q.size() != 0 &&
						!(req_q[0].drain && operand_due.size() != 0)) begin
					nx = req_q.pop_front();
					func <= nx.func;
					operand_field <= nx.field;
					set_flags <= nx.sf;
					rm_value <= nx.rm;
					rs_value <= nx.rs;
					in_valid <= 1'b1;
					tx_gap <= draw_wait(tx_calm);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and result checker
	always @(posedge clk or negedge arst_n) begin
		op_res_t     exp_r;
		int unsigned nxt;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait <= 0;
		end else begin
			nxt = rx_wait;
			if (out_valid && out_ready) begin
				if (operand_due.size() == 0) begin
					if (n_bad < 10)
						$display("unexpected result: value %08h carry %0b write %0b",
							operand_value, carry_out, carry_write);
					n_bad = n_bad + 1;
				end else begin
					exp_r = operand_due.pop_front();
					if (operand_value !== exp_r.value || carry_out !== exp_r.cy ||
							carry_write !== exp_r.cw) begin
						if (n_bad < 10)
							$display({"mismatch: value %08h/%08h carry %0b/%0b ",
								"write %0b/%0b (exp/got)"},
								exp_r.value, operand_value, exp_r.cy, carry_out,
								exp_r.cw, carry_write);
						n_bad = n_bad + 1;
					end
				end
				nxt = draw_wait(rx_calm);
			end else if (nxt > 0) begin
				nxt = nxt - 1;
			end
			rx_wait <= nxt;
			out_ready <= (nxt == 0);
		end
	end

	initial begin
		op_req_t     r;
		int unsigned pick;
		// rotated immediates
		add_imm(12'h0FF, 1'b1);
		add_imm(12'hFFF, 1'b0);
		add_imm(12'h480, 1'b1);
		add_imm(12'h101, 1'b0);
		add_imm(12'h000, 1'b1);
		// amount from the field, zero shift included
		add_shift(SH_LSL, 1'b0, 0, 1'b1, 32'hFFFF_FFFF);
		add_shift(SH_LSL, 1'b0, 31, 1'b1, 32'h0000_0001);
		add_shift(SH_LSR, 1'b0, 31, 1'b1, 32'h8000_0000);
		add_shift(SH_LSR, 1'b0, 0, 1'b0, 32'h8000_0001);
		add_shift(SH_ASR, 1'b0, 1, 1'b1, 32'h8000_0001);
		add_shift(SH_ASR, 1'b0, 31, 1'b0, 32'h7FFF_FFFF);
		add_shift(SH_ROR, 1'b0, 0, 1'b1, 32'h1234_5678);
		add_shift(SH_ROR, 1'b0, 31, 1'b1, 32'h8000_0001);
		// amount from rs, mostly at and beyond the word width, with zero and one as well
		add_shift(SH_LSL, 1'b1, 32, 1'b1, 32'h0000_0001);
		add_shift(SH_LSR, 1'b1, 32, 1'b1, 32'h8000_0000);
		add_shift(SH_ASR, 1'b1, 32, 1'b1, 32'h8000_0000);
		add_shift(SH_ASR, 1'b1, 32, 1'b0, 32'h7FFF_FFFF);
		add_shift(SH_LSL, 1'b1, 33, 1'b1, 32'hFFFF_FFFF);
		add_shift(SH_LSR, 1'b1, 200, 1'b1, 32'hFFFF_FFFF);
		add_shift(SH_ASR, 1'b1, 255, 1'b1, 32'h8000_0000);
		add_shift(SH_LSR, 1'b1, 0, 1'b1, 32'hDEAD_BEEF);
		add_shift(SH_ROR, 1'b1, 32, 1'b1, 32'hA5A5_0F0F);
		add_shift(SH_ROR, 1'b1, 255, 1'b0, 32'hA5A5_0F0F);
		add_shift(SH_LSL, 1'b1, 1, 1'b1, 32'h8000_0000);
		for (int i = 0; i < 1500; i++) begin
			r.func = ($urandom_range(0, 2) == 0);
			r.field = FIELD_W'($urandom);
			r.sf = 1'($urandom);
			r.rs = $urandom;
			pick = $urandom_range(0, 7);
			r.rm = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF :
				(pick == 2) ? 32'h8000_0000 : $urandom;
			// keep rs amounts within 0 to 34 most of the time
			pick = $urandom_range(0, 7);
			if (pick < 4)
				r.rs[7:0] = 8'($urandom_range(0, 34));
			else if (pick == 4)
				r.rs[7:0] = 8'd32;
			r.drain = (i == 0 || i == 700 || i == 1400);
			req_q.push_back(r);
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (req_q.size() != 0 || in_valid || operand_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (n_bad == 0 && operand_due.size() == 0)
			$display("** arm_operand2_barrel_shifter_unit: PASSED **");
		else
			$display("** arm_operand2_barrel_shifter_unit: FAILED **");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("** arm_operand2_barrel_shifter_unit: FAILED **");
		$finish;
	end
endmodule

[filelist.f]
+incdir+sv
sv/aobs_pkg.sv
sv/aobs_decode.sv
sv/arm_operand2_barrel_shifter_unit.sv
dv/tb.sv
